FILE: rtl/core/bsh_pkg.sv
// ----------------------------------------------------------------------------
// bsh_pkg
// Shared widths, sequencer step codes, constants and helpers for the byte
// string hash.
// ----------------------------------------------------------------------------
package bsh_pkg;

    localparam int HASH_W   = 32;
    localparam int LEN_BITS = 24;
    localparam int TLEN_W   = 24;
    localparam int K_W      = 15;
    localparam int ST_W     = 4;

    localparam logic [LEN_BITS-1:0] LEN_MASK = LEN_BITS'(32'h00ff_ffff);

    // sequencer steps
    localparam logic [ST_W-1:0] S_IDLE = 4'd0;
    localparam logic [ST_W-1:0] S_C1   = 4'd1;
    localparam logic [ST_W-1:0] S_C2   = 4'd2;
    localparam logic [ST_W-1:0] S_C3   = 4'd3;
    localparam logic [ST_W-1:0] S_T1   = 4'd4;
    localparam logic [ST_W-1:0] S_T2   = 4'd5;
    localparam logic [ST_W-1:0] S_T3   = 4'd6;
    localparam logic [ST_W-1:0] S_T4   = 4'd7;
    localparam logic [ST_W-1:0] S_F1   = 4'd8;
    localparam logic [ST_W-1:0] S_F2   = 4'd9;
    localparam logic [ST_W-1:0] S_F3   = 4'd10;

    typedef struct packed {
        logic [ST_W-1:0]     step;
        logic [ST_W-1:0]     prev;
        logic [LEN_BITS-1:0] n;
    } t_ctrl;

    // multiplier constant used by each multiply step
    function automatic logic [K_W-1:0] f_mul_k(input logic [ST_W-1:0] s);
        logic [K_W-1:0] k;
        k = '0;
        unique case (s)
            S_C1:    k = K_W'(509);
            S_C2:    k = K_W'(5309);
            S_T1:    k = K_W'(7703);
            S_T2:    k = K_W'(7717);
            S_T3:    k = K_W'(9323);
            S_T4:    k = K_W'(7727);
            S_F1:    k = K_W'(29311);
            S_F2:    k = K_W'(7321);
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [HASH_W-1:0] f_sbyte(input logic [7:0] b);
        return {{(HASH_W-8){b[7]}}, b};
    endfunction

endpackage

FILE: rtl/core/bsh_in_if.sv
// ----------------------------------------------------------------------------
// bsh_in_if
// Input channel: four string bytes per beat plus start marker and length.
// ----------------------------------------------------------------------------
interface bsh_in_if;
    logic                        valid;
    logic                        ready;
    logic [31:0]                 data_word;
    logic                        start_req;
    logic [bsh_pkg::TLEN_W-1:0]  total_length;

    modport source (output valid, data_word, start_req, total_length, input ready);
    modport sink   (input valid, data_word, start_req, total_length, output ready);
endinterface

FILE: rtl/core/bsh_out_if.sv
// ----------------------------------------------------------------------------
// bsh_out_if
// Output channel: one 32-bit hash per beat.
// ----------------------------------------------------------------------------
interface bsh_out_if;
    logic                        valid;
    logic                        ready;
    logic [bsh_pkg::HASH_W-1:0]  hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

FILE: rtl/core/byte_string_hash.sv
// ----------------------------------------------------------------------------
// byte_string_hash
// Hashes a byte string four bytes per beat with two accumulators and a final
// mix, every multiply step sharing one registered constant multiplier.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   handshake
//  i_in     in   data_word, start_req, total_length        valid / ready
//  o_out    out  hash_value                                valid / ready
//
//  a chunk beat keeps ready low after acceptance while steps C1, C2 and C3 run
//  the last beat keeps ready low through one multiply step per tail byte,
//  then the 3 mix steps and any stall of the last one; an empty string runs
//  only the mix steps; the single multiplier makes all these steps run in turn
//  the result sits in an output register, so a new string may start meanwhile
//  a full output register stalls the last mix step until it is taken
//  reset is synchronous, active low, and leaves the block idle
// ----------------------------------------------------------------------------
module byte_string_hash (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsh_in_if.sink    i_in,
    bsh_out_if.source o_out
);
    import bsh_pkg::*;

    t_ctrl               w_ctrl;
    logic                w_idle;
    logic                w_acc;
    logic                w_load;
    logic                w_hold;
    logic                w_mul_en;
    logic [HASH_W-1:0]   w_mul_a;
    logic [HASH_W-1:0]   w_prod;
    logic [HASH_W-1:0]   w_b0, w_b1, w_b2, w_b3;
    logic [HASH_W-1:0]   w_n32;
    logic [HASH_W-1:0]   w_mix;
    logic [HASH_W-1:0]   w_hash;

    logic [HASH_W-1:0]   r_a1, n_a1;
    logic [HASH_W-1:0]   r_a2, n_a2;
    logic [HASH_W-1:0]   r_t, n_t;
    logic [31:0]         r_word, n_word;
    logic [LEN_BITS-1:0] r_len, n_len;
    logic [HASH_W-1:0]   r_hash;
    logic                r_ov;

    assign w_acc  = i_in.valid && i_in.ready;
    assign w_load = (w_ctrl.step == S_F3) && (!r_ov || o_out.ready);
    assign w_hold = (w_ctrl.step == S_F3) && !w_load;

    bsh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_start (i_in.start_req),
        .i_len   (LEN_BITS'(i_in.total_length)),
        .i_hold  (w_hold),
        .o_ctrl  (w_ctrl),
        .o_idle  (w_idle)
    );

    assign w_b0  = f_sbyte(r_word[7:0]);
    assign w_b1  = f_sbyte(r_word[15:8]);
    assign w_b2  = f_sbyte(r_word[23:16]);
    assign w_b3  = f_sbyte(r_word[31:24]);
    assign w_n32 = HASH_W'(w_ctrl.n);

    // input capture and accumulator write-back of the product from the previous step
    always_comb begin
        n_a1   = r_a1;
        n_a2   = r_a2;
        n_t    = r_t;
        n_word = r_word;
        n_len  = r_len;
        if (w_acc) begin
            n_word = i_in.data_word;
            if (i_in.start_req) begin
                n_a1  = '0;
                n_a2  = HASH_W'(LEN_BITS'(i_in.total_length));
                n_len = LEN_BITS'(i_in.total_length);
            end
        end
        unique case (w_ctrl.prev)
            S_C1: n_a1 = (w_prod + w_b0 * HASH_W'(307)) ^ (w_b1 * HASH_W'(1319));
            S_C2: n_a2 = ((w_n32 << 4) + w_n32 + HASH_W'(5) + w_prod)
                         ^ (w_b2 * HASH_W'(3313) + w_b3 * HASH_W'(9337) + HASH_W'(517));
            S_T1: n_a1 = w_prod ^ (w_b0 * HASH_W'(503));
            S_T2: n_a2 = w_prod ^ (w_b1 * HASH_W'(509));
            S_T3: n_a1 = w_prod ^ (HASH_W'(11) + w_b2 * HASH_W'(523));
            S_T4: n_a2 = (w_prod + HASH_W'(127)) ^ (HASH_W'(313) + w_b3 * HASH_W'(547));
            S_F1: n_t  = w_prod + HASH_W'(59);
            default: ;
        endcase
    end

    // operand takes the accumulator value being written this cycle
    assign w_mul_a  = (w_ctrl.step == S_T1 || w_ctrl.step == S_T3 || w_ctrl.step == S_F1)
                      ? n_a1 : n_a2;
    assign w_mul_en = (w_ctrl.step != S_IDLE) && (w_ctrl.step != S_C3)
                      && (w_ctrl.step != S_F3);

    bsh_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_k    (f_mul_k(w_ctrl.step)),
        .o_prod (w_prod)
    );

    // final mix with zero fallbacks
    assign w_mix = r_t ^ (w_prod + HASH_W'(120501));

    always_comb begin
        w_hash = w_mix;
        if (w_mix == '0) begin
            if (r_a1 != '0) begin
                w_hash = r_a1;
            end else if (r_a2 != '0) begin
                w_hash = r_a2;
            end else begin
                w_hash = HASH_W'(r_len & LEN_MASK) + HASH_W'(11);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1  <= '0;
            r_a2  <= '0;
            r_len <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_a1  <= n_a1;
            r_a2  <= n_a2;
            r_len <= n_len;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t    <= n_t;
        r_word <= n_word;
        if (w_load) begin
            r_hash <= w_hash;
        end
    end

    assign i_in.ready       = w_idle;
    assign o_out.valid      = r_ov;
    assign o_out.hash_value = r_hash;

endmodule

FILE: rtl/core/bsh_mul.sv
// ----------------------------------------------------------------------------
// bsh_mul
// Shared constant multiplier: registered low word of operand times constant.
// ----------------------------------------------------------------------------
module bsh_mul (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [bsh_pkg::HASH_W-1:0]    i_a,
    input  logic [bsh_pkg::K_W-1:0]       i_k,
    output logic [bsh_pkg::HASH_W-1:0]    o_prod
);
    import bsh_pkg::*;

    logic [HASH_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * HASH_W'(i_k);
        end
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/core/bsh_ctrl.sv
// ----------------------------------------------------------------------------
// bsh_ctrl
// Step sequencer: chunk, tail and final mix steps, and the remaining byte count.
// ----------------------------------------------------------------------------
module bsh_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_acc,
    input  logic                          i_start,
    input  logic [bsh_pkg::LEN_BITS-1:0]  i_len,
    input  logic                          i_hold,
    output bsh_pkg::t_ctrl                o_ctrl,
    output logic                          o_idle
);
    import bsh_pkg::*;

    logic [ST_W-1:0]     r_step, n_step;
    logic [ST_W-1:0]     r_prev, n_prev;
    logic [LEN_BITS-1:0] r_n, n_n;

    always_comb begin
        n_step = r_step;
        n_prev = r_step;
        n_n    = r_n;
        if (i_hold) begin
            n_prev = r_prev;
        end else begin
            unique case (r_step)
                S_IDLE: begin
                    if (i_acc) begin
                        if (i_start) begin
                            n_n = i_len;
                            if (i_len == '0) begin
                                n_step = S_F1;
                            end else if (i_len > LEN_BITS'(4)) begin
                                n_step = S_C1;
                            end else begin
                                n_step = S_T1;
                            end
                        end else if (r_n != '0) begin
                            n_step = (r_n > LEN_BITS'(4)) ? S_C1 : S_T1;
                        end
                    end
                end
                S_C1: n_step = S_C2;
                S_C2: n_step = S_C3;
                S_C3: begin
                    n_n    = r_n - LEN_BITS'(4);
                    n_step = S_IDLE;
                end
                S_T1: n_step = (r_n >= LEN_BITS'(2)) ? S_T2 : S_F1;
                S_T2: n_step = (r_n >= LEN_BITS'(3)) ? S_T3 : S_F1;
                S_T3: n_step = (r_n >= LEN_BITS'(4)) ? S_T4 : S_F1;
                S_T4: n_step = S_F1;
                S_F1: n_step = S_F2;
                S_F2: n_step = S_F3;
                S_F3: begin
                    n_n    = '0;
                    n_step = S_IDLE;
                end
                default: n_step = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
            r_prev <= S_IDLE;
            r_n    <= '0;
        end else begin
            r_step <= n_step;
            r_prev <= n_prev;
            r_n    <= n_n;
        end
    end

    assign o_ctrl.step = r_step;
    assign o_ctrl.prev = r_prev;
    assign o_ctrl.n    = r_n;
    assign o_idle      = (r_step == S_IDLE);

endmodule

FILE: sim/byte_string_hash_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_string_hash_chk
// Watches the input and output channels of the byte string hash. It keeps its
// own copy of the accumulators and the length count, predicts the hash of
// each completed string, and compares every output beat with the oldest
// prediction.
// ----------------------------------------------------------------------------
module byte_string_hash_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [31:0]                 i_data_word,
    input  logic                        i_start_req,
    input  logic [bsh_pkg::TLEN_W-1:0]  i_total_length,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [bsh_pkg::HASH_W-1:0]  i_hash_value,
    output int                          o_err_count,
    output int                          o_hash_count,
    output int                          o_pending
);
    import bsh_pkg::*;

    logic [31:0]         acc_a;
    logic [31:0]         acc_b;
    logic [LEN_BITS-1:0] left_n;
    logic [LEN_BITS-1:0] str_len;
    logic [31:0]         hash_q [$];
    logic [31:0]         want_hash;
    int                  err_n;
    int                  hash_n;

    function automatic logic [31:0] byte_at(input logic [31:0] w, input int k);
        logic [7:0] b;
        b = w[8*k +: 8];
        return {{24{b[7]}}, b};
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        err_n++;
    endtask

    // tail bytes, final mix and its zero fallbacks
    task automatic close_string(input logic [31:0] w, input logic [LEN_BITS-1:0] n);
        logic [31:0] h;
        if (n >= 1) acc_a = (acc_a * 32'd7703) ^ (32'd503 * byte_at(w, 0));
        if (n >= 2) acc_b = (acc_b * 32'd7717) ^ (32'd509 * byte_at(w, 1));
        if (n >= 3) acc_a = (acc_a * 32'd9323) ^ (32'd11 + 32'd523 * byte_at(w, 2));
        if (n >= 4) acc_b = (acc_b * 32'd7727 + 32'd127) ^ (32'd313 + 32'd547 * byte_at(w, 3));
        h = (acc_a * 32'd29311 + 32'd59) ^ (acc_b * 32'd7321 + 32'd120501);
        if (h == '0) begin
            h = (acc_a != '0) ? acc_a : acc_b;
            if (h == '0) h = 32'(str_len & 24'hff_ffff) + 32'd11;
        end
        hash_q.insert(hash_q.size(), h);
    endtask

    task automatic take_beat(input logic [31:0] w, input logic st,
                             input logic [TLEN_W-1:0] tl);
        logic [31:0]         prev_b;
        logic [LEN_BITS-1:0] n;
        if (st) begin
            str_len = LEN_BITS'(tl) & LEN_MASK;
            acc_a   = '0;
            acc_b   = 32'(str_len);
            left_n  = str_len;
            if (str_len == '0) begin
                close_string(w, '0);
                return;
            end
        end else if (left_n == '0) begin
            return;
        end
        n = left_n;
        if (n > 4) begin
            prev_b = acc_b;
            acc_a  = (32'd509 * prev_b + 32'd307 * byte_at(w, 0)) ^ (32'd1319 * byte_at(w, 1));
            acc_b  = (32'd17 * 32'(n) + 32'd5 + 32'd5309 * prev_b)
                   ^ (32'd3313 * byte_at(w, 2) + 32'd9337 * byte_at(w, 3) + 32'd517);
            left_n = n - LEN_BITS'(4);
        end else begin
            left_n = '0;
            close_string(w, n);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            acc_a   = '0;
            acc_b   = '0;
            left_n  = '0;
            str_len = '0;
            hash_q.delete();
        end else begin
            // output first: a hash leaving now never comes from this edge's input beat
            if (i_out_valid && i_out_ready) begin
                if (hash_q.size() == 0) begin
                    flag_mismatch($sformatf("hash %08h with no string pending", i_hash_value));
                end else begin
                    want_hash = hash_q.pop_front();
                    hash_n++;
                    if (i_hash_value !== want_hash)
                        flag_mismatch($sformatf("hash_value %08h, predicted %08h",
                                                i_hash_value, want_hash));
                end
            end
            if (i_in_valid && i_in_ready)
                take_beat(i_data_word, i_start_req, i_total_length);
        end
        o_err_count  <= err_n;
        o_hash_count <= hash_n;
        o_pending    <= hash_q.size();
    end

endmodule

FILE: sim/byte_string_hash_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_string_hash_tb
// Drives byte strings into the hash block: a directed set of corner strings
// (empty, one to four bytes, extreme bytes, a zero mix, restarts, stray beats)
// and then random strings with cut and stray beats, with random idle bursts
// on both channels. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module byte_string_hash_tb;
    import bsh_pkg::*;

    localparam int         STRING_BEATS = 1950;
    localparam int         CALM_BEATS   = 1650;
    localparam logic [7:0] CORNER_BYTES [4] = '{8'h00, 8'h7f, 8'h80, 8'hff};

    logic        clk;
    logic        rst_n;
    bit          calm    = 1'b0;
    bit          gaps_on = 1'b1;
    int          driven;
    int          ignored_beats;
    int          strings_sent;
    int          cut_strings;
    int          err_count;
    int          hash_count;
    int          pending;
    logic        zm_found;
    logic [31:0] zm_word0;
    logic [31:0] zm_word1;

    bsh_in_if  in_ch ();
    bsh_out_if out_ch ();

    byte_string_hash u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    byte_string_hash_chk u_chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_ch.valid),
        .i_in_ready     (in_ch.ready),
        .i_data_word    (in_ch.data_word),
        .i_start_req    (in_ch.start_req),
        .i_total_length (in_ch.total_length),
        .i_out_valid    (out_ch.valid),
        .i_out_ready    (out_ch.ready),
        .i_hash_value   (out_ch.hash_value),
        .o_err_count    (err_count),
        .o_hash_count   (hash_count),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d hashes still pending", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [31:0] sext8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        w = $urandom;
        for (int k = 0; k < 4; k++)
            if ($urandom_range(0, 3) == 0) w[8*k +: 8] = CORNER_BYTES[$urandom_range(0, 3)];
        return w;
    endfunction

    // meet in the middle over an 8-byte string: one chunk then a full tail,
    // looking for bytes whose final mix comes out zero
    task automatic find_zero_mix();
        int          idx_by_key [logic [31:0]];
        logic [31:0] a;
        logic [31:0] h;
        logic [31:0] key;
        logic [7:0]  b0, b1, b2, b3, c0, c1, c2, c3;
        int          hit;
        zm_found = 1'b0;
        zm_word0 = '0;
        zm_word1 = '0;
        for (int i = 0; i < 262144; i++) begin
            b0 = i[7:0];
            b1 = i[15:8];
            c0 = {6'b0, i[17:16]};
            a  = (32'd4072 + 32'd307 * sext8(b0)) ^ (32'd1319 * sext8(b1));
            h  = (a * 32'd7703) ^ (32'd503 * sext8(c0));
            h  = (h * 32'd9323) ^ (32'd11 + 32'd523 * sext8(8'h00));
            idx_by_key[h * 32'd29311 + 32'd59] = i;
        end
        for (int j = 0; j < 131072 && !zm_found; j++) begin
            b2  = j[7:0];
            b3  = j[15:8];
            c1  = {7'b0, j[16]};
            c3  = 8'h00;
            a   = 32'd42613 ^ (32'd3313 * sext8(b2) + 32'd9337 * sext8(b3) + 32'd517);
            h   = (a * 32'd7717) ^ (32'd509 * sext8(c1));
            h   = (h * 32'd7727 + 32'd127) ^ (32'd313 + 32'd547 * sext8(c3));
            key = h * 32'd7321 + 32'd120501;
            if (idx_by_key.exists(key)) begin
                hit      = idx_by_key[key];
                zm_found = 1'b1;
                zm_word0 = {b3, b2, hit[15:8], hit[7:0]};
                zm_word1 = {c3, 8'h00, c1, 6'b0, hit[17:16]};
            end
        end
    endtask

    task automatic drive_beat(input logic [31:0] w, input logic st,
                              input logic [TLEN_W-1:0] tl);
        @(negedge clk);
        if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid        = 1'b0;
            in_ch.data_word    = $urandom;
            in_ch.start_req    = 1'($urandom);
            in_ch.total_length = TLEN_W'($urandom);
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.data_word    = w;
        in_ch.start_req    = st;
        in_ch.total_length = tl;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        driven++;
    endtask

    task automatic send_string(input logic [TLEN_W-1:0] len, input int nbeats);
        drive_beat(pick_word(), 1'b1, len);
        for (int k = 1; k < nbeats; k++)
            drive_beat(pick_word(), 1'b0, TLEN_W'($urandom));
        strings_sent++;
    endtask

    // output side: random stall bursts, none once the run is calm
    initial begin
        int n;
        out_ch.ready = 1'b0;
        @(negedge clk);
        forever begin
            if (calm || $urandom_range(0, 2) != 0) begin
                out_ch.ready = 1'b1;
                n = calm ? 1 : $urandom_range(1, ($urandom_range(0, 7) == 0) ? 200 : 30);
            end else begin
                out_ch.ready = 1'b0;
                n = $urandom_range(1, 17);
            end
            repeat (n) @(negedge clk);
        end
    end

    initial begin
        logic [TLEN_W-1:0] len;
        int                pick;
        int                nb;
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.data_word    = '0;
        in_ch.start_req    = 1'b0;
        in_ch.total_length = '0;
        find_zero_mix();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners
        drive_beat(32'hffff_ffff, 1'b0, 24'hff_ffff);
        ignored_beats++;
        drive_beat(32'hffff_ffff, 1'b1, 24'd0);
        drive_beat(32'h0000_0080, 1'b1, 24'd1);
        drive_beat(32'h0000_007f, 1'b1, 24'd1);
        drive_beat(32'hffff_8080, 1'b1, 24'd2);
        drive_beat(32'h00ff_7f80, 1'b1, 24'd3);
        drive_beat(32'hffff_ffff, 1'b1, 24'd4);
        drive_beat(32'h8080_8080, 1'b1, 24'd4);
        drive_beat(32'h7f7f_7f7f, 1'b1, 24'd4);
        drive_beat(32'h0000_0000, 1'b1, 24'd4);
        drive_beat(32'h807f_80ff, 1'b1, 24'd5);
        drive_beat(32'h0000_00ff, 1'b0, 24'd0);
        if (zm_found) begin
            drive_beat(zm_word0, 1'b1, 24'd8);
            drive_beat(zm_word1, 1'b0, 24'd0);
            strings_sent++;
        end else begin
            send_string(24'd8, 2);
        end
        // restarts mid-string, then a stray beat after completion
        drive_beat(32'h1234_5678, 1'b1, 24'hff_ffff);
        drive_beat(32'h8765_4321, 1'b0, 24'd0);
        drive_beat(32'hdead_beef, 1'b1, 24'h80_0000);
        drive_beat(32'hffff_ffff, 1'b1, 24'd3);
        drive_beat(32'h0000_0001, 1'b0, 24'd0);
        ignored_beats++;
        strings_sent += 13;
        cut_strings  += 2;

        // random strings
        while (driven - ignored_beats < STRING_BEATS) begin
            calm    = (driven - ignored_beats) >= CALM_BEATS;
            gaps_on = ($urandom_range(0, 9) >= 3);
            pick    = $urandom_range(0, 99);
            if (pick < 8) begin
                len = TLEN_W'($urandom);
                send_string(len, $urandom_range(1, 4));
                cut_strings++;
            end else if (pick < 12) begin
                drive_beat(pick_word(), 1'b0, TLEN_W'($urandom));
                ignored_beats++;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 5)       len = '0;
                else if (pick < 60) len = TLEN_W'($urandom_range(1, 16));
                else if (pick < 90) len = TLEN_W'($urandom_range(17, 64));
                else                len = TLEN_W'($urandom_range(65, 400));
                nb = (len == '0) ? 1 : (int'(len) + 3) / 4;
                send_string(len, nb);
            end
        end
        send_string(24'd7, 2);

        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (5000) begin
            if (pending == 0) break;
            @(negedge clk);
        end
        repeat (20) @(negedge clk);

        $display("run: %0d beats driven (%0d stray), %0d strings, %0d cut short by a restart",
                 driven, ignored_beats, strings_sent, cut_strings);
        $display("run: %0d hashes compared, zero-mix string %s, %0d errors, %0d left pending",
                 hash_count, zm_found ? "driven" : "not found", err_count, pending);
        if (err_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
